// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/irfi_pkg.sv =====
`timescale 1ns / 1ps

package irfi_pkg;

    // Default frame store geometry
    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    // Register widths and reset values
    localparam int MODE_W = 3;
    localparam int DIM_W  = 9;
    localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;
    localparam logic [DIM_W-1:0]  DIM_RESET  = 9'd256;

    // APB register map
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_ROWS = 2'd2;

    // Transform modes
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_L    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT_R    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLIP_H   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLIP_V   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INVERT   = 3'd5;

    // Pixel layout: red in the low byte, then green, then blue
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam logic [CH_W-1:0] CHANNEL_MAX = 8'd255;

    typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ===== rtl/irfi_ram.sv =====
`timescale 1ns / 1ps

module irfi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/image_rotate_flip_invert_unit.sv =====
`timescale 1ns / 1ps
// Timing: a load transaction is written to the frame store at the edge that accepts it;
// an emit transaction's pixel passes the frame store's read register, then the output buffer.
// Throughput: one transaction per cycle, set by the single port of the frame store;
// s_tready drops while the buffered pixels plus the read in flight, less a pixel leaving
// in the same cycle, already fill the two-entry output buffer.
// Reset: mode 0, both dimensions 256, all four counters zero, output buffer empty.
// The frame store is not cleared; the user must load an entry before an emit reads it.
`include "assert_macros.svh"

module image_rotate_flip_invert_unit #(
    parameter int MAX_COLS = irfi_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = irfi_pkg::MAX_ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irfi_pkg::APB_AW-1:0] paddr,
    input  logic [irfi_pkg::APB_DW-1:0] pwdata,
    output logic [irfi_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                        s_tuser,   // action: 0 load, 1 emit
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // out_red[7:0], out_green[15:8],
                                                   // out_blue[23:16]
    output logic                        m_tlast    // last_pixel
);

    localparam int MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int CW    = $clog2(MAXD);
    localparam int DW    = $clog2(MAXD + 1);
    localparam int EW    = (DW > irfi_pkg::DIM_W) ? DW : irfi_pkg::DIM_W;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [irfi_pkg::MODE_W-1:0] mode_reg;
    logic [irfi_pkg::DIM_W-1:0]  cols_reg;
    logic [irfi_pkg::DIM_W-1:0]  rows_reg;
    logic                        cfg_wr;
    logic [1:0]                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= irfi_pkg::MODE_RESET;
            cols_reg <= irfi_pkg::DIM_RESET;
            rows_reg <= irfi_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                irfi_pkg::REG_MODE: mode_reg <= pwdata[irfi_pkg::MODE_W-1:0];
                irfi_pkg::REG_COLS: cols_reg <= pwdata[irfi_pkg::DIM_W-1:0];
                irfi_pkg::REG_ROWS: rows_reg <= pwdata[irfi_pkg::DIM_W-1:0];
                default:            ;   // write beyond the map: drop it
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            irfi_pkg::REG_MODE: prdata = irfi_pkg::APB_DW'(mode_reg);
            irfi_pkg::REG_COLS: prdata = irfi_pkg::APB_DW'(cols_reg);
            irfi_pkg::REG_ROWS: prdata = irfi_pkg::APB_DW'(rows_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective dimensions: zero counts as one, clamp to the store size
    // ------------------------------------------------------------------
    logic [EW-1:0] cols_ext;
    logic [EW-1:0] rows_ext;
    logic [DW-1:0] cols_eff;
    logic [DW-1:0] rows_eff;
    logic          rotated;
    logic [DW-1:0] orows;
    logic [DW-1:0] ocols;

    always_comb
    begin
        cols_ext = EW'(cols_reg);
        rows_ext = EW'(rows_reg);
        priority if (cols_ext == '0)
            cols_eff = DW'(1);
        else if (cols_ext > EW'(MAX_COLS))
            cols_eff = DW'(MAX_COLS);
        else
            cols_eff = DW'(cols_ext);
        priority if (rows_ext == '0)
            rows_eff = DW'(1);
        else if (rows_ext > EW'(MAX_ROWS))
            rows_eff = DW'(MAX_ROWS);
        else
            rows_eff = DW'(rows_ext);
    end

    assign rotated = (mode_reg == irfi_pkg::MODE_ROT_L) || (mode_reg == irfi_pkg::MODE_ROT_R);
    assign orows   = rotated ? cols_eff : rows_eff;
    assign ocols   = rotated ? rows_eff : cols_eff;

    // ------------------------------------------------------------------
    // Handshake and output buffer occupancy
    // ------------------------------------------------------------------
    logic       s_acc;
    logic       pop;
    logic       pend_reg;
    logic [1:0] cnt_reg;
    logic [2:0] occ;

    assign pop      = m_tvalid && m_tready;
    // Hold input while buffered results plus the read in flight would overflow.
    assign occ      = 3'({1'b0, cnt_reg}) + 3'(pend_reg) - 3'(pop);
    assign s_tready = (occ <= 3'd1);
    assign s_acc    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Load counters: raster order of the source image
    // ------------------------------------------------------------------
    logic [CW-1:0] lr_reg, lr_next;
    logic [CW-1:0] lc_reg, lc_next;
    logic [CW-1:0] lr_cur, lc_cur;
    logic [DW-1:0] lr_inc, lc_inc;
    logic [AW-1:0] wr_addr;

    always_comb
    begin
        // Restart at the first pixel if the dimensions shrank under the counters.
        if ((DW'(lr_reg) >= rows_eff) || (DW'(lc_reg) >= cols_eff))
        begin
            lr_cur = '0;
            lc_cur = '0;
        end
        else
        begin
            lr_cur = lr_reg;
            lc_cur = lc_reg;
        end
        lc_inc = DW'(lc_cur) + DW'(1);
        lr_inc = DW'(lr_cur) + DW'(1);
        if (lc_inc >= cols_eff)
        begin
            lc_next = '0;
            lr_next = (lr_inc >= rows_eff) ? '0 : CW'(lr_inc);
        end
        else
        begin
            lc_next = CW'(lc_inc);
            lr_next = lr_cur;
        end
        wr_addr = AW'(lr_cur) * COLS_A + AW'(lc_cur);
    end

    // ------------------------------------------------------------------
    // Emit counters: raster order of the transformed image
    // ------------------------------------------------------------------
    logic [CW-1:0] er_reg, er_next;
    logic [CW-1:0] ec_reg, ec_next;
    logic [CW-1:0] er_cur, ec_cur;
    logic [DW-1:0] er_inc, ec_inc;
    logic [DW-1:0] src_r, src_c;
    logic [AW-1:0] rd_addr;
    logic          emit_last;

    always_comb
    begin
        if ((DW'(er_reg) >= orows) || (DW'(ec_reg) >= ocols))
        begin
            er_cur = '0;
            ec_cur = '0;
        end
        else
        begin
            er_cur = er_reg;
            ec_cur = ec_reg;
        end
        ec_inc = DW'(ec_cur) + DW'(1);
        er_inc = DW'(er_cur) + DW'(1);
        if (ec_inc >= ocols)
        begin
            ec_next = '0;
            er_next = (er_inc >= orows) ? '0 : CW'(er_inc);
        end
        else
        begin
            ec_next = CW'(ec_inc);
            er_next = er_cur;
        end
        emit_last = (er_inc == orows) && (ec_inc == ocols);

        // Map the output position back to its source pixel.
        unique case (mode_reg)
            irfi_pkg::MODE_ROT_L:
            begin
                src_r = DW'(ec_cur);
                src_c = cols_eff - DW'(1) - DW'(er_cur);
            end
            irfi_pkg::MODE_ROT_R:
            begin
                src_r = rows_eff - DW'(1) - DW'(ec_cur);
                src_c = DW'(er_cur);
            end
            irfi_pkg::MODE_FLIP_H:
            begin
                src_r = DW'(er_cur);
                src_c = cols_eff - DW'(1) - DW'(ec_cur);
            end
            irfi_pkg::MODE_FLIP_V:
            begin
                src_r = rows_eff - DW'(1) - DW'(er_cur);
                src_c = DW'(ec_cur);
            end
            default:
            begin
                // identity, invert and the unused codes
                src_r = DW'(er_cur);
                src_c = DW'(ec_cur);
            end
        endcase
        rd_addr = AW'(src_r) * COLS_A + AW'(src_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= '0;
            lc_reg <= '0;
            er_reg <= '0;
            ec_reg <= '0;
        end
        else if (s_acc)
        begin
            if (s_tuser)
            begin
                er_reg <= er_next;
                ec_reg <= ec_next;
            end
            else
            begin
                lr_reg <= lr_next;
                lc_reg <= lc_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame store: one port, a load writes, an emit reads
    // ------------------------------------------------------------------
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    irfi_pkg::pixel_t     ram_rdata;

    assign ram_we   = s_acc && !s_tuser;
    assign ram_addr = s_tuser ? rd_addr : wr_addr;

    irfi_ram #(
        .WIDTH (irfi_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    // Read in flight: its invert and last flags travel alongside.
    logic pend_inv_reg;
    logic pend_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= s_acc && s_tuser;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser)
        begin
            pend_inv_reg  <= (mode_reg == irfi_pkg::MODE_INVERT);
            pend_last_reg <= emit_last;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer, head in slot 0
    // ------------------------------------------------------------------
    irfi_pkg::pixel_t push_pix;
    irfi_pkg::pixel_t b0_pix_reg, b1_pix_reg;
    logic             b0_last_reg, b1_last_reg;
    logic [1:0]       slot;

    // 255 minus a channel is the channel with every bit flipped.
    assign push_pix = ram_rdata ^ (pend_inv_reg ? {3{irfi_pkg::CHANNEL_MAX}} : '0);
    assign slot     = cnt_reg - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(pend_reg) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b0_pix_reg  <= b1_pix_reg;
            b0_last_reg <= b1_last_reg;
        end
        if (pend_reg)
        begin
            if (slot == 2'd0)
            begin
                b0_pix_reg  <= push_pix;
                b0_last_reg <= pend_last_reg;
            end
            else
            begin
                b1_pix_reg  <= push_pix;
                b1_last_reg <= pend_last_reg;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = b0_pix_reg;
    assign m_tlast  = b0_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_PROP(a_pend_room, clk, rst_n, pend_reg |-> (cnt_reg <= 2'd1), "no room for read data")
    `ASSERT_PROP(a_read_issue, clk, rst_n, (s_acc && s_tuser) |=> pend_reg, "emit read lost")
    `ASSERT_PROP(a_emit_range, clk, rst_n, (s_acc && s_tuser) |=> ((DW'(er_reg) < orows) && (DW'(ec_reg) < ocols)), "emit counters out of range")
    `ASSERT_NEVER(a_buf_over, clk, rst_n, (cnt_reg == 2'd3), "output buffer overflow")

endmodule
